### rtl/core/mmh_pkg.sv
// Shared types and constants for the max-min heap queue.
// No dependencies; every other file refers to this package by scoped names.
package mmh_pkg;

    localparam int OPCODE_BITS    = 3;
    localparam int STATUS_BITS    = 3;
    localparam int SUM_BITS       = 40;
    localparam int COUNT_OUT_BITS = 9;
    localparam logic [2:0] TD_LAST_CAND = 3'd6;

    typedef enum logic [OPCODE_BITS-1:0] {
        OPC_INSERT    = 3'd0,
        OPC_DEL_MAX   = 3'd1,
        OPC_DEL_ENTRY = 3'd2,
        OPC_SUM_MIN   = 3'd3,
        OPC_SUM_MAX   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_DEL_MAX   = 3'd1,
        CMD_DEL_ENTRY = 3'd2,
        CMD_SUM_MIN   = 3'd3,
        CMD_SUM_MAX   = 3'd4,
        CMD_NOP       = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RD_ROOT, S_ROOT_GOT, S_LOAD_LAST,
        S_TD_START, S_TD_SCAN, S_TD_DEC, S_TD_W2, S_TD_PM, S_TD_END,
        S_BU_LOAD, S_BU_START, S_BU_PAR, S_CL_START, S_CL_CMP, S_DONE
    } eng_state_t;

    // Queue handshake between front and engine
    typedef struct packed {
        logic push;
        logic full;
    } q_in_ctl_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } q_out_ctl_t;

    // Level 0 (root) and every even level are max levels.
    function automatic logic level_is_max(input logic [31:0] idx);
        logic [32:0] v;
        logic        odd;
        v   = {1'b0, idx} + 33'd1;
        odd = 1'b0;
        for (int b = 0; b < 33; b++) begin
            if (v[b]) begin
                odd = b[0];
            end
        end
        return !odd;
    endfunction

endpackage

### rtl/core/mmh_front.sv
// Input side of the heap queue: takes transfers and classifies the opcode.
// Depends on mmh_pkg; feeds mmh_cmd_queue.
module mmh_front #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mmh_pkg::OPCODE_BITS-1:0]       s_opcode,
    input  logic [KEY_BITS-1:0]                   s_item_key,
    input  logic [TAG_BITS-1:0]                   s_item_tag,
    output mmh_pkg::q_in_ctl_t                    q_ctl_out,
    input  logic                                  q_full,
    output logic [3+KEY_BITS+TAG_BITS-1:0]        q_data
);

    mmh_pkg::cmd_t cmd;

    always_comb begin
        unique case (s_opcode)
            mmh_pkg::OPC_INSERT:    cmd = mmh_pkg::CMD_INSERT;
            mmh_pkg::OPC_DEL_MAX:   cmd = mmh_pkg::CMD_DEL_MAX;
            mmh_pkg::OPC_DEL_ENTRY: cmd = mmh_pkg::CMD_DEL_ENTRY;
            mmh_pkg::OPC_SUM_MIN:   cmd = mmh_pkg::CMD_SUM_MIN;
            mmh_pkg::OPC_SUM_MAX:   cmd = mmh_pkg::CMD_SUM_MAX;
            default:                cmd = mmh_pkg::CMD_NOP;
        endcase
    end

    assign s_ready        = !q_full;
    assign q_ctl_out.push = s_valid && !q_full;
    assign q_ctl_out.full = q_full;
    assign q_data         = {cmd, s_item_key, s_item_tag};

endmodule

### rtl/core/mmh_cmd_queue.sv
// Two-entry command queue between the front and the heap engine.
// Depends on mmh_pkg for the control structs.
module mmh_cmd_queue #(
    parameter int WIDTH = 51
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mmh_pkg::q_in_ctl_t in_ctl,
    input  logic [WIDTH-1:0]   in_data,
    output logic               full,
    input  mmh_pkg::q_out_ctl_t out_ctl,
    output logic               out_valid,
    output logic [WIDTH-1:0]   out_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign do_push   = in_ctl.push && !full;
    assign do_pop    = out_ctl.pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/core/mmh_engine.sv
// Heap engine: entry RAM, scan unit, trickle-down and bubble-up sequencer,
// and the result register. Depends on mmh_pkg.
module mmh_engine #(
    parameter int HEAP_CAPACITY = 256,
    parameter int KEY_BITS      = 32,
    parameter int TAG_BITS      = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     q_valid,
    input  logic [3+KEY_BITS+TAG_BITS-1:0]           q_data,
    output mmh_pkg::q_out_ctl_t                      q_ctl,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [mmh_pkg::STATUS_BITS-1:0]          m_status,
    output logic [KEY_BITS-1:0]                      m_out_key,
    output logic [TAG_BITS-1:0]                      m_out_tag,
    output logic [mmh_pkg::SUM_BITS-1:0]             m_level_sum,
    output logic [mmh_pkg::COUNT_OUT_BITS-1:0]       m_entry_count
);

    localparam int AW  = $clog2(HEAP_CAPACITY);
    localparam int CW  = $clog2(HEAP_CAPACITY + 1);
    localparam int IW  = CW + 3;
    localparam int EW  = KEY_BITS + TAG_BITS;
    localparam int SW  = mmh_pkg::SUM_BITS;
    localparam int COW = mmh_pkg::COUNT_OUT_BITS;

    // Entry RAM
    logic [EW-1:0] mem [HEAP_CAPACITY];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [EW-1:0] wd;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    mmh_pkg::eng_state_t state_reg, state_next;
    mmh_pkg::cmd_t       op_reg, op_next;
    mmh_pkg::status_t    status_reg, status_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [EW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       xpos_reg, xpos_next;
    logic                track_reg, track_next;
    logic                want_max_reg, want_max_next;
    logic                bub_after_reg, bub_after_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                pend_v_reg, pend_v_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [2:0]          pend_k_reg, pend_k_next;
    logic [2:0]          k_reg, k_next;
    logic [EW-1:0]       best_reg, best_next;
    logic [AW-1:0]       m_idx_reg, m_idx_next;
    logic                grand_reg, grand_next;
    logic [EW-1:0]       ch0_reg, ch0_next;
    logic [EW-1:0]       ch1_reg, ch1_next;
    logic                dup_reg, dup_next;
    logic                hit_found_reg, hit_found_next;
    logic [AW-1:0]       hit_reg, hit_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [KEY_BITS-1:0] okey_reg, okey_next;
    logic [TAG_BITS-1:0] otag_reg, otag_next;

    logic                         m_valid_reg, m_valid_next;
    logic [mmh_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [KEY_BITS-1:0]          m_key_reg, m_key_next;
    logic [TAG_BITS-1:0]          m_tag_reg, m_tag_next;
    logic [SW-1:0]                m_sum_reg, m_sum_next;
    logic [COW-1:0]               m_cnt_reg, m_cnt_next;

    // Derived values
    logic [KEY_BITS-1:0] rd_key, cur_key, best_key, pm_key;
    logic [TAG_BITS-1:0] rd_tag;
    logic [CW-1:0]       cnt_m1;
    logic [IW-1:0]       c0, cand;
    logic                pm_is_c1;
    logic [AW-1:0]       pm_idx, par_idx, gp_idx;
    logic [EW-1:0]       pm_entry;
    logic                mx;

    assign rd_key   = rd_data_reg[EW-1:TAG_BITS];
    assign rd_tag   = rd_data_reg[TAG_BITS-1:0];
    assign cur_key  = cur_reg[EW-1:TAG_BITS];
    assign best_key = best_reg[EW-1:TAG_BITS];
    assign cnt_m1   = count_reg - CW'(1);
    assign c0       = (IW'(pos_reg) << 1) + IW'(1);
    assign pm_is_c1 = (IW'(m_idx_reg) >= ((c0 << 1) + IW'(3)));
    assign pm_idx   = pm_is_c1 ? AW'(c0 + IW'(1)) : AW'(c0);
    assign pm_entry = pm_is_c1 ? ch1_reg : ch0_reg;
    assign pm_key   = pm_entry[EW-1:TAG_BITS];
    assign par_idx  = (pos_reg - AW'(1)) >> 1;
    assign gp_idx   = (par_idx - AW'(1)) >> 1;
    assign mx       = mmh_pkg::level_is_max(32'(pos_reg));

    always_comb begin
        unique case (k_reg)
            3'd0:    cand = c0;
            3'd1:    cand = (c0 << 1) + IW'(1);
            3'd2:    cand = (c0 << 1) + IW'(2);
            3'd3:    cand = c0 + IW'(1);
            3'd4:    cand = (c0 << 1) + IW'(3);
            default: cand = (c0 << 1) + IW'(4);
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        xpos_next      = xpos_reg;
        track_next     = track_reg;
        want_max_next  = want_max_reg;
        bub_after_next = bub_after_reg;
        scan_next      = scan_reg;
        pend_v_next    = pend_v_reg;
        pend_idx_next  = pend_idx_reg;
        pend_k_next    = pend_k_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        m_idx_next     = m_idx_reg;
        grand_next     = grand_reg;
        ch0_next       = ch0_reg;
        ch1_next       = ch1_reg;
        dup_next       = dup_reg;
        hit_found_next = hit_found_reg;
        hit_next       = hit_reg;
        sum_next       = sum_reg;
        okey_next      = okey_reg;
        otag_next      = otag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_key_next     = m_key_reg;
        m_tag_next     = m_tag_reg;
        m_sum_next     = m_sum_reg;
        m_cnt_next     = m_cnt_reg;
        q_ctl.valid    = q_valid;
        q_ctl.pop      = 1'b0;
        rd_addr        = '0;
        we             = 1'b0;
        wa             = pos_reg;
        wd             = cur_reg;

        unique case (state_reg)
            mmh_pkg::S_IDLE: begin
                if (q_valid) begin
                    q_ctl.pop      = 1'b1;
                    op_next        = mmh_pkg::cmd_t'(q_data[3+EW-1:EW]);
                    key_next       = q_data[EW-1:TAG_BITS];
                    tag_next       = q_data[TAG_BITS-1:0];
                    status_next    = mmh_pkg::ST_OK;
                    okey_next      = '0;
                    otag_next      = '0;
                    sum_next       = '0;
                    dup_next       = 1'b0;
                    hit_found_next = 1'b0;
                    scan_next      = '0;
                    pend_v_next    = 1'b0;
                    unique case (mmh_pkg::cmd_t'(q_data[3+EW-1:EW]))
                        mmh_pkg::CMD_NOP: state_next = mmh_pkg::S_DONE;
                        mmh_pkg::CMD_DEL_MAX: begin
                            if (count_reg == '0) begin
                                status_next = mmh_pkg::ST_EMPTY;
                                state_next  = mmh_pkg::S_DONE;
                            end else begin
                                state_next = mmh_pkg::S_RD_ROOT;
                            end
                        end
                        default: state_next = mmh_pkg::S_SCAN;
                    endcase
                end
            end
            mmh_pkg::S_SCAN: begin
                rd_addr       = scan_reg[AW-1:0];
                pend_v_next   = (scan_reg < count_reg);
                pend_idx_next = scan_reg[AW-1:0];
                if (scan_reg < count_reg) begin
                    scan_next = scan_reg + CW'(1);
                end
                if (pend_v_reg) begin
                    if (op_reg == mmh_pkg::CMD_INSERT && rd_tag == tag_reg) begin
                        dup_next = 1'b1;
                    end
                    if (op_reg == mmh_pkg::CMD_DEL_ENTRY && rd_tag == tag_reg &&
                        rd_key == key_reg && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_next       = pend_idx_reg;
                    end
                    if (mmh_pkg::level_is_max(32'(pend_idx_reg)) ==
                        (op_reg == mmh_pkg::CMD_SUM_MAX)) begin
                        sum_next = sum_reg + SW'(rd_key);
                    end
                end
                if (!(scan_reg < count_reg) && !pend_v_reg) begin
                    state_next = mmh_pkg::S_DECIDE;
                end
            end
            mmh_pkg::S_DECIDE: begin
                priority case (op_reg)
                    mmh_pkg::CMD_INSERT: begin
                        if (dup_reg) begin
                            status_next = mmh_pkg::ST_DUP;
                            state_next  = mmh_pkg::S_DONE;
                        end else if (count_reg == CW'(HEAP_CAPACITY)) begin
                            status_next = mmh_pkg::ST_FULL;
                            state_next  = mmh_pkg::S_DONE;
                        end else begin
                            cur_next   = {key_reg, tag_reg};
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = mmh_pkg::S_BU_START;
                        end
                    end
                    mmh_pkg::CMD_DEL_ENTRY: begin
                        if (count_reg == '0) begin
                            status_next = mmh_pkg::ST_EMPTY;
                            state_next  = mmh_pkg::S_DONE;
                        end else if (!hit_found_reg) begin
                            status_next = mmh_pkg::ST_NOT_FOUND;
                            state_next  = mmh_pkg::S_DONE;
                        end else begin
                            count_next = cnt_m1;
                            if (hit_reg == cnt_m1[AW-1:0]) begin
                                state_next = mmh_pkg::S_DONE;
                            end else begin
                                rd_addr        = cnt_m1[AW-1:0];
                                pos_next       = hit_reg;
                                bub_after_next = 1'b1;
                                state_next     = mmh_pkg::S_LOAD_LAST;
                            end
                        end
                    end
                    default: state_next = mmh_pkg::S_DONE;
                endcase
            end
            mmh_pkg::S_RD_ROOT: begin
                rd_addr    = '0;
                state_next = mmh_pkg::S_ROOT_GOT;
            end
            mmh_pkg::S_ROOT_GOT: begin
                okey_next      = rd_key;
                otag_next      = rd_tag;
                count_next     = cnt_m1;
                rd_addr        = cnt_m1[AW-1:0];
                pos_next       = '0;
                bub_after_next = 1'b0;
                state_next     = mmh_pkg::S_LOAD_LAST;
            end
            mmh_pkg::S_LOAD_LAST: begin
                cur_next   = rd_data_reg;
                xpos_next  = pos_reg;
                track_next = 1'b1;
                state_next = mmh_pkg::S_TD_START;
            end
            mmh_pkg::S_TD_START: begin
                if (c0 >= IW'(count_reg)) begin
                    we         = 1'b1;
                    state_next = mmh_pkg::S_TD_END;
                end else begin
                    k_next      = '0;
                    pend_v_next = 1'b0;
                    state_next  = mmh_pkg::S_TD_SCAN;
                end
            end
            mmh_pkg::S_TD_SCAN: begin
                rd_addr       = cand[AW-1:0];
                pend_v_next   = (k_reg != mmh_pkg::TD_LAST_CAND) && (cand < IW'(count_reg));
                pend_idx_next = cand[AW-1:0];
                pend_k_next   = k_reg;
                if (k_reg != mmh_pkg::TD_LAST_CAND) begin
                    k_next = k_reg + 3'd1;
                end
                if (pend_v_reg) begin
                    if (pend_k_reg == 3'd0) begin
                        ch0_next = rd_data_reg;
                    end
                    if (pend_k_reg == 3'd3) begin
                        ch1_next = rd_data_reg;
                    end
                    if (pend_k_reg == 3'd0 ||
                        (mx ? (rd_key > best_key) : (rd_key < best_key))) begin
                        best_next  = rd_data_reg;
                        m_idx_next = pend_idx_reg;
                        grand_next = (pend_k_reg != 3'd0) && (pend_k_reg != 3'd3);
                    end
                end
                if (k_reg == mmh_pkg::TD_LAST_CAND && !pend_v_reg) begin
                    state_next = mmh_pkg::S_TD_DEC;
                end
            end
            mmh_pkg::S_TD_DEC: begin
                we = 1'b1;
                if (!(mx ? (best_key > cur_key) : (best_key < cur_key))) begin
                    state_next = mmh_pkg::S_TD_END;
                end else begin
                    wd = best_reg;
                    if (!grand_reg) begin
                        if (track_reg) begin
                            xpos_next = m_idx_reg;
                        end
                        state_next = mmh_pkg::S_TD_W2;
                    end else if (mx ? (cur_key < pm_key) : (cur_key > pm_key)) begin
                        state_next = mmh_pkg::S_TD_PM;
                    end else begin
                        if (track_reg) begin
                            xpos_next = m_idx_reg;
                        end
                        pos_next   = m_idx_reg;
                        state_next = mmh_pkg::S_TD_START;
                    end
                end
            end
            mmh_pkg::S_TD_W2: begin
                we         = 1'b1;
                wa         = m_idx_reg;
                state_next = mmh_pkg::S_TD_END;
            end
            mmh_pkg::S_TD_PM: begin
                we       = 1'b1;
                wa       = pm_idx;
                cur_next = pm_entry;
                if (track_reg) begin
                    xpos_next  = pm_idx;
                    track_next = 1'b0;
                end
                pos_next   = m_idx_reg;
                state_next = mmh_pkg::S_TD_START;
            end
            mmh_pkg::S_TD_END: begin
                if (bub_after_reg) begin
                    rd_addr    = xpos_reg;
                    state_next = mmh_pkg::S_BU_LOAD;
                end else begin
                    state_next = mmh_pkg::S_DONE;
                end
            end
            mmh_pkg::S_BU_LOAD: begin
                cur_next   = rd_data_reg;
                pos_next   = xpos_reg;
                state_next = mmh_pkg::S_BU_START;
            end
            mmh_pkg::S_BU_START: begin
                if (pos_reg == '0) begin
                    we         = 1'b1;
                    state_next = mmh_pkg::S_DONE;
                end else begin
                    rd_addr    = par_idx;
                    state_next = mmh_pkg::S_BU_PAR;
                end
            end
            mmh_pkg::S_BU_PAR: begin
                if (mx ? (cur_key < rd_key) : (cur_key > rd_key)) begin
                    we            = 1'b1;
                    wd            = rd_data_reg;
                    pos_next      = par_idx;
                    want_max_next = !mx;
                end else begin
                    want_max_next = mx;
                end
                state_next = mmh_pkg::S_CL_START;
            end
            mmh_pkg::S_CL_START: begin
                if (pos_reg < AW'(3)) begin
                    we         = 1'b1;
                    state_next = mmh_pkg::S_DONE;
                end else begin
                    rd_addr    = gp_idx;
                    state_next = mmh_pkg::S_CL_CMP;
                end
            end
            mmh_pkg::S_CL_CMP: begin
                we = 1'b1;
                if (want_max_reg ? (cur_key > rd_key) : (cur_key < rd_key)) begin
                    wd         = rd_data_reg;
                    pos_next   = gp_idx;
                    state_next = mmh_pkg::S_CL_START;
                end else begin
                    state_next = mmh_pkg::S_DONE;
                end
            end
            mmh_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_key_next    = okey_reg;
                    m_tag_next    = otag_reg;
                    m_sum_next    = (op_reg == mmh_pkg::CMD_SUM_MIN ||
                                     op_reg == mmh_pkg::CMD_SUM_MAX) ? sum_reg : '0;
                    m_cnt_next    = COW'(count_reg);
                    state_next    = mmh_pkg::S_IDLE;
                end
            end
            default: state_next = mmh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmh_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        key_reg       <= key_next;
        tag_reg       <= tag_next;
        cur_reg       <= cur_next;
        pos_reg       <= pos_next;
        xpos_reg      <= xpos_next;
        track_reg     <= track_next;
        want_max_reg  <= want_max_next;
        bub_after_reg <= bub_after_next;
        scan_reg      <= scan_next;
        pend_v_reg    <= pend_v_next;
        pend_idx_reg  <= pend_idx_next;
        pend_k_reg    <= pend_k_next;
        k_reg         <= k_next;
        best_reg      <= best_next;
        m_idx_reg     <= m_idx_next;
        grand_reg     <= grand_next;
        ch0_reg       <= ch0_next;
        ch1_reg       <= ch1_next;
        dup_reg       <= dup_next;
        hit_found_reg <= hit_found_next;
        hit_reg       <= hit_next;
        sum_reg       <= sum_next;
        okey_reg      <= okey_next;
        otag_reg      <= otag_next;
        m_status_reg  <= m_status_next;
        m_key_reg     <= m_key_next;
        m_tag_reg     <= m_tag_next;
        m_sum_reg     <= m_sum_next;
        m_cnt_reg     <= m_cnt_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_key     = m_key_reg;
    assign m_out_tag     = m_tag_reg;
    assign m_level_sum   = m_sum_reg;
    assign m_entry_count = m_cnt_reg;

endmodule

### rtl/core/max_min_heap_queue.sv
// Top level of the max-min heap queue: front, command queue, heap engine.
// Depends on mmh_pkg, mmh_front, mmh_cmd_queue and mmh_engine.
//
//   channel | ports                                         | direction
//   s_      | opcode, item_key, item_tag                    | in
//   m_      | status, out_key, out_tag, level_sum, entry_cnt| out
//
// A transfer is registered in the command queue before it reaches the engine. For
// sums, inserts and delete-entry the engine first scans every held entry; an insert
// then bubbles up, climbing by grandparent steps, a delete-entry trickles down and
// bubbles up, and a delete-max reads the root and trickles the last entry down. The
// engine makes one entry RAM access at a time.
// Reset clears the entry count and the queue; the RAM needs no clearing.
// Two commands can wait in the queue while a result stalls on m_ready.
module max_min_heap_queue #(
    parameter int HEAP_CAPACITY = 256,
    parameter int KEY_BITS      = 32,
    parameter int TAG_BITS      = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mmh_pkg::OPCODE_BITS-1:0]       s_opcode,
    input  logic [KEY_BITS-1:0]                   s_item_key,
    input  logic [TAG_BITS-1:0]                   s_item_tag,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mmh_pkg::STATUS_BITS-1:0]       m_status,
    output logic [KEY_BITS-1:0]                   m_out_key,
    output logic [TAG_BITS-1:0]                   m_out_tag,
    output logic [mmh_pkg::SUM_BITS-1:0]          m_level_sum,
    output logic [mmh_pkg::COUNT_OUT_BITS-1:0]    m_entry_count
);

    localparam int QW  = 3 + KEY_BITS + TAG_BITS;
    localparam int COW = mmh_pkg::COUNT_OUT_BITS;

    mmh_pkg::q_in_ctl_t  q_in_ctl;
    mmh_pkg::q_out_ctl_t q_out_ctl;
    logic [QW-1:0]       q_in_data, q_out_data;
    logic                q_full, q_valid;

    mmh_front #(
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_item_key (s_item_key),
        .s_item_tag (s_item_tag),
        .q_ctl_out  (q_in_ctl),
        .q_full     (q_full),
        .q_data     (q_in_data)
    );

    mmh_cmd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (q_in_ctl),
        .in_data   (q_in_data),
        .full      (q_full),
        .out_ctl   (q_out_ctl),
        .out_valid (q_valid),
        .out_data  (q_out_data)
    );

    mmh_engine #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .KEY_BITS      (KEY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_out_data),
        .q_ctl         (q_out_ctl),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_tag     (m_out_tag),
        .m_level_sum   (m_level_sum),
        .m_entry_count (m_entry_count)
    );

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == mmh_pkg::ST_FULL |-> m_entry_count == COW'(HEAP_CAPACITY))
        else $error("full status with entry count below capacity");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == mmh_pkg::ST_EMPTY |-> m_entry_count == '0)
        else $error("empty status with entries held");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != mmh_pkg::ST_OK |->
            m_out_key == '0 && m_out_tag == '0 && m_level_sum == '0)
        else $error("error result carries nonzero payload");

endmodule

### verif/tb.sv
// Testbench for max_min_heap_queue: random and directed heap commands, with a
// built-in heap predictor checking every result transfer field by field.
// Depends on mmh_pkg and the max_min_heap_queue RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CAP      = 256;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] key;
        logic [15:0] tag;
        bit          drain_first;
    } cmd_item_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] key;
        logic [15:0] tag;
        logic [39:0] sum;
        logic [8:0]  count;
    } heap_result_t;

    typedef struct {
        logic [31:0] key;
        logic [15:0] tag;
    } entry_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [31:0] s_item_key = '0;
    logic [15:0] s_item_tag = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_status;
    logic [31:0] m_out_key;
    logic [15:0] m_out_tag;
    logic [39:0] m_level_sum;
    logic [8:0]  m_entry_count;

    max_min_heap_queue dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // heap predictor state
    logic [31:0] hk [CAP];
    logic [15:0] ht [CAP];
    int unsigned hcnt = 0;

    cmd_item_t    cmd_q [$];
    heap_result_t result_q [$];
    entry_t       inserted [$];
    int           errors = 0;

    function automatic bit max_level(int unsigned i);
        int unsigned v = i + 1;
        int unsigned l = 0;
        while (v > 1) begin
            v >>= 1;
            l++;
        end
        return l[0] == 1'b0;
    endfunction

    function automatic void hswap(int unsigned a, int unsigned b);
        logic [31:0] k = hk[a];
        logic [15:0] t = ht[a];
        hk[a] = hk[b];
        ht[a] = ht[b];
        hk[b] = k;
        ht[b] = t;
    endfunction

    function automatic void climb(int unsigned i, bit want_max);
        int unsigned g;
        while (i >= 3) begin
            g = (((i - 1) >> 1) - 1) >> 1;
            if (!(want_max ? hk[i] > hk[g] : hk[i] < hk[g])) break;
            hswap(i, g);
            i = g;
        end
    endfunction

    function automatic void sift_up(int unsigned i);
        int unsigned p;
        if (i == 0) return;
        p = (i - 1) >> 1;
        if (max_level(i)) begin
            if (hk[i] < hk[p]) begin
                hswap(i, p);
                climb(p, 0);
            end else climb(i, 1);
        end else begin
            if (hk[i] > hk[p]) begin
                hswap(i, p);
                climb(p, 1);
            end else climb(i, 0);
        end
    endfunction

    function automatic int unsigned sift_down(int unsigned i);
        int unsigned xpos = i;
        bit tracking = 1;
        bit mx, grand;
        int unsigned c0, m, pm;
        forever begin
            mx = max_level(i);
            c0 = 2 * i + 1;
            grand = 0;
            if (c0 >= hcnt) break;
            m = c0;
            for (int unsigned j = c0; j <= c0 + 1 && j < hcnt; j++) begin
                if (mx ? hk[j] > hk[m] : hk[j] < hk[m]) begin
                    m = j;
                    grand = 0;
                end
                for (int unsigned k = 2 * j + 1; k <= 2 * j + 2 && k < hcnt; k++) begin
                    if (mx ? hk[k] > hk[m] : hk[k] < hk[m]) begin
                        m = k;
                        grand = 1;
                    end
                end
            end
            if (!(mx ? hk[m] > hk[i] : hk[m] < hk[i])) break;
            hswap(i, m);
            if (!grand) begin
                if (tracking) xpos = m;
                break;
            end
            pm = (m - 1) >> 1;
            if (mx ? hk[m] < hk[pm] : hk[m] > hk[pm]) begin
                hswap(m, pm);
                if (tracking) begin
                    xpos = pm;
                    tracking = 0;
                end
            end else if (tracking) xpos = m;
            i = m;
        end
        return xpos;
    endfunction

    function automatic heap_result_t heap_apply(logic [2:0] op, logic [31:0] key,
                                                logic [15:0] tag);
        heap_result_t r;
        bit dup;
        int unsigned hit;
        r.status = mmh_pkg::ST_OK;
        r.key = '0;
        r.tag = '0;
        r.sum = '0;
        case (op)
            mmh_pkg::OPC_INSERT: begin
                dup = 0;
                for (int unsigned i = 0; i < hcnt; i++) if (ht[i] == tag) dup = 1;
                if (dup) r.status = mmh_pkg::ST_DUP;
                else if (hcnt >= CAP) r.status = mmh_pkg::ST_FULL;
                else begin
                    hk[hcnt] = key;
                    ht[hcnt] = tag;
                    hcnt++;
                    sift_up(hcnt - 1);
                end
            end
            mmh_pkg::OPC_DEL_MAX: begin
                if (hcnt == 0) r.status = mmh_pkg::ST_EMPTY;
                else begin
                    r.key = hk[0];
                    r.tag = ht[0];
                    hcnt--;
                    hk[0] = hk[hcnt];
                    ht[0] = ht[hcnt];
                    if (hcnt > 1) void'(sift_down(0));
                end
            end
            mmh_pkg::OPC_DEL_ENTRY: begin
                if (hcnt == 0) r.status = mmh_pkg::ST_EMPTY;
                else begin
                    hit = hcnt;
                    for (int unsigned i = 0; i < hcnt; i++)
                        if (ht[i] == tag && hk[i] == key) begin
                            hit = i;
                            break;
                        end
                    if (hit == hcnt) r.status = mmh_pkg::ST_NOT_FOUND;
                    else begin
                        hcnt--;
                        if (hit < hcnt) begin
                            hk[hit] = hk[hcnt];
                            ht[hit] = ht[hcnt];
                            sift_up(sift_down(hit));
                        end
                    end
                end
            end
            mmh_pkg::OPC_SUM_MIN, mmh_pkg::OPC_SUM_MAX: begin
                for (int unsigned i = 0; i < hcnt; i++)
                    if (max_level(i) == (op == mmh_pkg::OPC_SUM_MAX))
                        r.sum += {8'd0, hk[i]};
            end
            default: ;
        endcase
        r.count = hcnt[8:0];
        return r;
    endfunction

    // stimulus helpers
    function automatic void add_cmd(logic [2:0] op, logic [31:0] key, logic [15:0] tag,
                                    bit drain = 0);
        cmd_item_t c;
        c.op = op;
        c.key = key;
        c.tag = tag;
        c.drain_first = drain;
        cmd_q.push_back(c);
        if (op == mmh_pkg::OPC_INSERT) inserted.push_back('{key, tag});
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_tag();
        if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 300));
        return 16'($urandom);
    endfunction

    // driver
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                result_q.push_back(heap_apply(s_opcode, s_item_key, s_item_tag));
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (cmd_q.size() > 0 &&
                             !(cmd_q[0].drain_first && result_q.size() != 0)) begin
                    s_valid <= 1'b1;
                    s_opcode <= cmd_q[0].op;
                    s_item_key <= cmd_q[0].key;
                    s_item_tag <= cmd_q[0].tag;
                    void'(cmd_q.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int rx_count = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int unsigned cyc = 0;
    heap_result_t exp_r;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_count <= rx_count + 1;
                if (result_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, m_status);
                        errors++;
                    end
                    if (m_out_key !== exp_r.key) begin
                        $error("out_key: expected %0h actual %0h", exp_r.key, m_out_key);
                        errors++;
                    end
                    if (m_out_tag !== exp_r.tag) begin
                        $error("out_tag: expected %0h actual %0h", exp_r.tag, m_out_tag);
                        errors++;
                    end
                    if (m_level_sum !== exp_r.sum) begin
                        $error("level_sum: expected %0h actual %0h", exp_r.sum, m_level_sum);
                        errors++;
                    end
                    if (m_entry_count !== exp_r.count) begin
                        $error("entry_count: expected %0d actual %0d", exp_r.count,
                               m_entry_count);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (rx_count == 150 && !hold_done) begin
                hold_left <= 1500;
                hold_done <= 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (cyc % 96 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        entry_t e;
        int sel;

        // directed
        add_cmd(mmh_pkg::OPC_DEL_MAX, 0, 0);
        add_cmd(mmh_pkg::OPC_DEL_ENTRY, 5, 5);
        add_cmd(mmh_pkg::OPC_SUM_MIN, 0, 0);
        add_cmd(mmh_pkg::OPC_SUM_MAX, 0, 0);
        add_cmd(3'd5, 32'hFFFF_FFFF, 16'hFFFF);
        add_cmd(3'd6, 0, 0);
        add_cmd(3'd7, 32'h1234_5678, 16'h00AA);
        add_cmd(mmh_pkg::OPC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        add_cmd(mmh_pkg::OPC_INSERT, 32'd0, 16'd0);
        add_cmd(mmh_pkg::OPC_INSERT, 32'd7, 16'hFFFF);
        add_cmd(mmh_pkg::OPC_INSERT, 32'd7, 16'd3);
        add_cmd(mmh_pkg::OPC_INSERT, 32'hFFFF_FFFF, 16'd4);
        add_cmd(mmh_pkg::OPC_INSERT, 32'd100, 16'd5);
        add_cmd(mmh_pkg::OPC_INSERT, 32'd50, 16'd6);
        add_cmd(mmh_pkg::OPC_SUM_MIN, 0, 0);
        add_cmd(mmh_pkg::OPC_SUM_MAX, 0, 0);
        add_cmd(mmh_pkg::OPC_DEL_ENTRY, 32'd8, 16'd3);
        add_cmd(mmh_pkg::OPC_DEL_ENTRY, 32'd7, 16'd3);
        add_cmd(mmh_pkg::OPC_DEL_ENTRY, 32'd0, 16'd0);
        add_cmd(mmh_pkg::OPC_DEL_MAX, 0, 0);
        add_cmd(mmh_pkg::OPC_DEL_MAX, 0, 0);
        add_cmd(mmh_pkg::OPC_SUM_MAX, 0, 0, 1);

        // random
        for (int r = 0; r < 850; r++) begin
            if (r == 300) begin
                // fill past capacity; large keys so the level sums carry into the high bits
                for (int j = 0; j < 262; j++)
                    add_cmd(mmh_pkg::OPC_INSERT,
                            ($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom),
                            16'(40000 + j));
                add_cmd(mmh_pkg::OPC_SUM_MIN, 0, 0);
                add_cmd(mmh_pkg::OPC_SUM_MAX, 0, 0);
                add_cmd(mmh_pkg::OPC_INSERT, 1, 16'(40001));
                for (int j = 0; j < 200; j++) add_cmd(mmh_pkg::OPC_DEL_MAX, 0, 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                add_cmd(mmh_pkg::OPC_INSERT, pick_key(), pick_tag());
            end else if (sel < 60) begin
                add_cmd(mmh_pkg::OPC_DEL_MAX, pick_key(), pick_tag());
            end else if (sel < 80) begin
                if (inserted.size() > 0 && $urandom_range(0, 9) < 7) begin
                    e = inserted[$urandom_range(0, inserted.size() - 1)];
                    add_cmd(mmh_pkg::OPC_DEL_ENTRY, e.key, e.tag);
                end else begin
                    add_cmd(mmh_pkg::OPC_DEL_ENTRY, pick_key(), pick_tag());
                end
            end else if (sel < 87) begin
                add_cmd(mmh_pkg::OPC_SUM_MIN, pick_key(), pick_tag());
            end else if (sel < 94) begin
                add_cmd(mmh_pkg::OPC_SUM_MAX, pick_key(), pick_tag(), r % 200 == 0);
            end else begin
                add_cmd(3'($urandom_range(5, 7)), $urandom, 16'($urandom));
            end
        end
        for (int j = 0; j < 40; j++) add_cmd(mmh_pkg::OPC_DEL_MAX, 0, 0);
        add_cmd(mmh_pkg::OPC_SUM_MIN, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (cmd_q.size() != 0 || s_valid || result_q.size() != 0);
        repeat (400) @(posedge aclk);

        if (errors == 0 && result_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
